// File: rtl/vess_pkg.sv
`timescale 1ns / 1ps

package vess_pkg;

    // output field widths, fixed by the result channel
    localparam int OUT_OFFSET_W = 32;
    localparam int OUT_COUNT_W  = 16;

    // result queue depth, holds two full bursts of two results
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // codec modes
    localparam logic [1:0] MODE_MPEG2   = 2'd0;
    localparam logic [1:0] MODE_H264    = 2'd1;
    localparam logic [1:0] MODE_H265    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // start code prefix last byte
    localparam logic [7:0] START_CODE_TAIL = 8'h01;

    // mpeg-2 start code values
    localparam logic [7:0] MPEG2_SEQ_HDR = 8'hB3;
    localparam logic [7:0] MPEG2_PICTURE = 8'h00;

    // h.264 nal unit types
    localparam logic [4:0] H264_SPS       = 5'd7;
    localparam logic [4:0] H264_SLICE     = 5'd1;
    localparam logic [4:0] H264_IDR_SLICE = 5'd5;

    // h.265 nal unit types
    localparam logic [5:0] H265_VPS     = 6'd33;
    localparam logic [5:0] H265_VCL_MAX = 6'd21;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_FRAME    = 2'd1,
        KIND_BOUNDARY = 2'd2
    } unit_kind_t;

    typedef struct packed {
        logic [OUT_OFFSET_W-1:0] segment_offset;
        logic [OUT_OFFSET_W-1:0] segment_size;
        logic [OUT_COUNT_W-1:0]  unit_count;
        logic [OUT_COUNT_W-1:0]  segment_index;
        logic                    final_segment;
        logic                    length_overflow;
    } result_t;

endpackage

// File: rtl/vess_classify.sv
`timescale 1ns / 1ps

module vess_classify
    import vess_pkg::*;
(
    input  logic [1:0]  codec_mode,
    input  logic [7:0]  type_byte,
    output unit_kind_t  kind
);

    logic [4:0] h264_type;
    logic [5:0] h265_type;

    assign h264_type = type_byte[4:0];
    assign h265_type = type_byte[6:1];

    // per-codec decode of the byte after the prefix
    always_comb begin
        kind = KIND_NONE;
        case (codec_mode)
            MODE_MPEG2: begin
                if (type_byte == MPEG2_SEQ_HDR) begin
                    kind = KIND_BOUNDARY;
                end else if (type_byte == MPEG2_PICTURE) begin
                    kind = KIND_FRAME;
                end
            end
            MODE_H264: begin
                if (h264_type == H264_SPS) begin
                    kind = KIND_BOUNDARY;
                end else if (h264_type == H264_SLICE || h264_type == H264_IDR_SLICE) begin
                    kind = KIND_FRAME;
                end
            end
            MODE_H265: begin
                if (h265_type == H265_VPS) begin
                    kind = KIND_BOUNDARY;
                end else if (h265_type <= H265_VCL_MAX) begin
                    kind = KIND_FRAME;
                end
            end
            MODE_UNKNOWN: begin
                kind = KIND_NONE;
            end
            default: begin
                kind = KIND_NONE;
            end
        endcase
    end

endmodule

// File: rtl/vess_core.sv
`timescale 1ns / 1ps

module vess_core
    import vess_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_en,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    input  logic [1:0]  codec_mode,
    output result_t     slot0,
    output result_t     slot1,
    output logic [1:0]  push_cnt
);

    localparam int OXW = (OFFSET_WIDTH > OUT_OFFSET_W) ? OFFSET_WIDTH : OUT_OFFSET_W;
    localparam int CXW = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0]  CNT_MAX = '1;

    function automatic logic [OUT_OFFSET_W-1:0] fit_off(input logic [OFFSET_WIDTH-1:0] v);
        logic [OXW-1:0] w;
        w = OXW'(v);
        return w[OUT_OFFSET_W-1:0];
    endfunction

    function automatic logic [OUT_COUNT_W-1:0] fit_cnt(input logic [COUNT_WIDTH-1:0] v);
        logic [CXW-1:0] w;
        w = CXW'(v);
        return w[OUT_COUNT_W-1:0];
    endfunction

    logic [7:0]              hist_reg [4];
    logic [2:0]              hist_cnt_reg;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic                    pos_sat_reg;
    logic                    open_reg;
    logic [OFFSET_WIDTH-1:0] open_off_reg;
    logic [COUNT_WIDTH-1:0]  open_frames_reg;
    logic [COUNT_WIDTH-1:0]  seg_idx_reg;

    logic [OFFSET_WIDTH-1:0] pos_next;
    logic                    pos_sat_next;
    logic                    open_next;
    logic [OFFSET_WIDTH-1:0] open_off_next;
    logic [COUNT_WIDTH-1:0]  open_frames_next;
    logic [COUNT_WIDTH-1:0]  seg_idx_next;

    logic                    pos_at_max;
    logic                    prefix_hit;
    logic                    lead_zero;
    logic [OFFSET_WIDTH-1:0] sc_base;
    logic [OFFSET_WIDTH-1:0] sc;
    unit_kind_t              kind;
    logic                    boundary;
    logic                    frame_unit;
    logic                    close_vld;
    logic                    eos_vld;
    logic [OFFSET_WIDTH-1:0] close_size;
    logic [OFFSET_WIDTH-1:0] eos_size;
    result_t                 close_res;
    result_t                 eos_res;

    vess_classify u_classify (
        .codec_mode (codec_mode),
        .type_byte  (data_byte),
        .kind       (kind)
    );

    // byte position, saturating with a sticky flag
    assign pos_at_max   = (pos_reg == OFF_MAX);
    assign pos_next     = pos_at_max ? pos_reg : pos_reg + OFFSET_WIDTH'(1);
    assign pos_sat_next = pos_sat_reg | pos_at_max;

    // 00 00 01 seen in the last three bytes, optional leading zero
    assign prefix_hit = (hist_cnt_reg >= 3'd3) && (hist_reg[2] == 8'h00) &&
                        (hist_reg[1] == 8'h00) && (hist_reg[0] == START_CODE_TAIL) &&
                        (pos_reg >= OFFSET_WIDTH'(3));
    assign sc_base    = pos_reg - OFFSET_WIDTH'(3);
    assign lead_zero  = (hist_cnt_reg == 3'd4) && (hist_reg[3] == 8'h00) &&
                        (sc_base != '0);
    assign sc         = lead_zero ? sc_base - OFFSET_WIDTH'(1) : sc_base;

    assign boundary   = prefix_hit && (kind == KIND_BOUNDARY);
    assign frame_unit = prefix_hit && (kind == KIND_FRAME);
    assign close_vld  = boundary && open_reg;

    // segment closed by a boundary
    assign close_size = (sc > open_off_reg) ? sc - open_off_reg : '0;

    always_comb begin
        close_res.segment_offset  = fit_off(open_off_reg);
        close_res.segment_size    = fit_off(close_size);
        close_res.unit_count      = fit_cnt(open_frames_reg);
        close_res.segment_index   = fit_cnt(seg_idx_reg);
        close_res.final_segment   = 1'b0;
        close_res.length_overflow = pos_sat_next;
    end

    // open segment after this byte's boundary or frame unit
    always_comb begin
        open_next        = open_reg | boundary;
        open_off_next    = boundary ? sc : open_off_reg;
        open_frames_next = open_frames_reg;
        if (boundary) begin
            open_frames_next = '0;
        end else if (frame_unit && open_reg && open_frames_reg != CNT_MAX) begin
            open_frames_next = open_frames_reg + COUNT_WIDTH'(1);
        end
        seg_idx_next = seg_idx_reg;
        if (close_vld && seg_idx_reg != CNT_MAX) begin
            seg_idx_next = seg_idx_reg + COUNT_WIDTH'(1);
        end
    end

    // last segment, runs to the end of the stream
    assign eos_vld  = end_of_stream && open_next;
    assign eos_size = (pos_next > open_off_next) ? pos_next - open_off_next : '0;

    always_comb begin
        eos_res.segment_offset  = fit_off(open_off_next);
        eos_res.segment_size    = fit_off(eos_size);
        eos_res.unit_count      = fit_cnt(open_frames_next);
        eos_res.segment_index   = fit_cnt(seg_idx_next);
        eos_res.final_segment   = 1'b1;
        eos_res.length_overflow = pos_sat_next;
    end

    // results in order, packed toward slot0, only on a byte transfer
    assign slot0    = close_vld ? close_res : eos_res;
    assign slot1    = eos_res;
    assign push_cnt = byte_en ? ({1'b0, close_vld} + {1'b0, eos_vld}) : 2'd0;

    // history bytes are payload, gated by the fill count
    always_ff @(posedge aclk) begin
        if (byte_en) begin
            hist_reg[3] <= hist_reg[2];
            hist_reg[2] <= hist_reg[1];
            hist_reg[1] <= hist_reg[0];
            hist_reg[0] <= data_byte;
        end
    end

    // stream state, cleared after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_cnt_reg    <= '0;
            pos_reg         <= '0;
            pos_sat_reg     <= 1'b0;
            open_reg        <= 1'b0;
            open_off_reg    <= '0;
            open_frames_reg <= '0;
            seg_idx_reg     <= '0;
        end else if (byte_en) begin
            if (end_of_stream) begin
                hist_cnt_reg    <= '0;
                pos_reg         <= '0;
                pos_sat_reg     <= 1'b0;
                open_reg        <= 1'b0;
                open_off_reg    <= '0;
                open_frames_reg <= '0;
                seg_idx_reg     <= '0;
            end else begin
                if (hist_cnt_reg != 3'd4) begin
                    hist_cnt_reg <= hist_cnt_reg + 3'd1;
                end
                pos_reg         <= pos_next;
                pos_sat_reg     <= pos_sat_next;
                open_reg        <= open_next;
                open_off_reg    <= open_off_next;
                open_frames_reg <= open_frames_next;
                seg_idx_reg     <= seg_idx_next;
            end
        end
    end

endmodule

// File: rtl/vess_res_queue.sv
`timescale 1ns / 1ps

module vess_res_queue
    import vess_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  result_t     slot0,
    input  result_t     slot1,
    input  logic [1:0]  push_cnt,
    output logic        room_for_two,
    output logic        head_valid,
    input  logic        head_pop,
    output result_t     head
);

    result_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   pop;

    assign pop          = head_pop && head_valid;
    assign head_valid   = (count_reg != '0);
    assign room_for_two = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign head         = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, up to two writes a cycle
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + QUEUE_PTR_W'(1)] <= slot1;
        end
    end

endmodule

// File: rtl/video_es_segment_scanner.sv
`timescale 1ns / 1ps
// channel   direction  handshake                payload
// cfg       in         cfg_valid / cfg_ready    cfg_data (codec_mode)
// s         in         s_valid / s_ready        s_data_byte, s_end_of_stream
// m         out        m_valid / m_ready        segment offset, size, frames, index, flags
//
// one stream byte per cycle while s_ready is high; its results enter the result queue at the same edge
// and m_* is driven from the registered queue head, not from the byte in flight
// a byte yields zero, one or two results, two only when a boundary lands on the last byte
// s_ready is high while the four-entry result queue has room for two results
// synchronous active-low reset clears stream state and sets codec_mode to MPEG-2
// the last byte of a stream returns stream state to reset; codec_mode is kept

module video_es_segment_scanner
    import vess_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_segment_offset,
    output logic [31:0] m_segment_size,
    output logic [15:0] m_unit_count,
    output logic [15:0] m_segment_index,
    output logic        m_final_segment,
    output logic        m_length_overflow
);

    logic [1:0] codec_mode_reg;
    logic       byte_en;
    result_t    slot0;
    result_t    slot1;
    logic [1:0] push_cnt;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign byte_en   = s_valid && s_ready;

    // codec mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= MODE_MPEG2;
        end else if (cfg_valid && cfg_ready) begin
            codec_mode_reg <= cfg_data;
        end
    end

    vess_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_en       (byte_en),
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .codec_mode    (codec_mode_reg),
        .slot0         (slot0),
        .slot1         (slot1),
        .push_cnt      (push_cnt)
    );

    vess_res_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .slot0        (slot0),
        .slot1        (slot1),
        .push_cnt     (push_cnt),
        .room_for_two (s_ready),
        .head_valid   (m_valid),
        .head_pop     (m_ready),
        .head         (head)
    );

    // result fields
    assign m_segment_offset  = head.segment_offset;
    assign m_segment_size    = head.segment_size;
    assign m_unit_count      = head.unit_count;
    assign m_segment_index   = head.segment_index;
    assign m_final_segment   = head.final_segment;
    assign m_length_overflow = head.length_overflow;

endmodule

// File: rtl/vess_checker.sv
`timescale 1ns / 1ps

module vess_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_ready,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_segment_offset,
    input logic [31:0] m_segment_size
);

    // reset empties the result queue and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result queue not empty after reset");

    // an empty result queue always has room for a byte
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result queue");

    // configuration writes are never stalled
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_segment_offset) &&
            $stable(m_segment_size))
        else $error("stalled result changed");

endmodule

bind video_es_segment_scanner vess_checker u_vess_checker (.*);
